// ===== src/shbt_pkg.sv =====
// Package: types, constants and sync-bit tables for the hazard tracker.
`timescale 1ns / 1ps
package shbt_pkg;
  localparam int RES_BITS_DEF   = 32;
  localparam int NUM_STAGES_DEF = 6;
  localparam int SYNC_W         = 12;
  localparam logic [SYNC_W-1:0] SYNC_HOST = 12'h800;

  localparam logic [2:0] OP_USAGE = 3'd0;
  localparam logic [2:0] OP_JOIN  = 3'd1;
  localparam logic [2:0] OP_CLRRD = 3'd2;
  localparam logic [2:0] OP_TAKE  = 3'd3;
  localparam logic [2:0] OP_FRAME = 3'd4;

  typedef struct packed {
    logic       go;
    logic [2:0] op;
  } shbt_cmd_t;

  function automatic logic [SYNC_W-1:0] sync_rd(input logic [2:0] s);
    case (s)
      3'd0: sync_rd = 12'h001;
      3'd1: sync_rd = 12'h004;
      3'd2: sync_rd = 12'h008;
      3'd3: sync_rd = 12'h020;
      3'd4: sync_rd = 12'h080;
      3'd5: sync_rd = 12'h600;
      default: sync_rd = '0;
    endcase
  endfunction

  function automatic logic [SYNC_W-1:0] sync_wr(input logic [2:0] s);
    case (s)
      3'd0: sync_wr = 12'h002;
      3'd1: sync_wr = 12'h000;
      3'd2: sync_wr = 12'h010;
      3'd3: sync_wr = 12'h040;
      3'd4: sync_wr = 12'h100;
      3'd5: sync_wr = 12'h600;
      default: sync_wr = '0;
    endcase
  endfunction
endpackage

// ===== src/stage_hazard_barrier_tracker_top.sv =====
// Top level of the stage hazard and barrier tracker.
`timescale 1ns / 1ps
// Takes one command word per cycle while the result register is empty or
// being taken, and returns its result word in the next cycle through an
// output register. The six-way row check and column update of the 6x6
// dependency matrices are combinational, ahead of that register.
module stage_hazard_barrier_tracker_top import shbt_pkg::*; #(
  parameter int RES_BITS   = RES_BITS_DEF,
  parameter int NUM_STAGES = NUM_STAGES_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  // operation[2:0], stage[5:3], read_mask[37:6], write_mask[69:38],
  // host_access[70], zero fill
  input  logic [71:0] in_tdata,
  output logic        out_tvalid,
  input  logic        out_tready,
  // src_barrier[11:0], dst_barrier[23:12], barrier_taken[24], zero fill
  output logic [31:0] out_tdata
);
  shbt_cmd_t         cmd;
  logic [SYNC_W-1:0] src_b, dst_b;
  logic              taken;

  shbt_ctrl u_ctrl (
    .clk, .rst_n, .in_tvalid, .in_tready, .op(in_tdata[2:0]),
    .out_tvalid, .out_tready, .cmd
  );

  shbt_dp #(.RES_BITS(RES_BITS), .NUM_STAGES(NUM_STAGES)) u_dp (
    .clk, .rst_n, .cmd,
    .stage(in_tdata[5:3]), .read_mask(in_tdata[37:6]),
    .write_mask(in_tdata[69:38]), .host_access(in_tdata[70]),
    .src_barrier(src_b), .dst_barrier(dst_b), .barrier_taken(taken)
  );

  assign out_tdata = {7'd0, taken, dst_b, src_b};
endmodule

// ===== src/shbt_dp.sv =====
// Datapath: dependency matrices, row hazard check and barrier accumulators.
`timescale 1ns / 1ps
module shbt_dp import shbt_pkg::*; #(
  parameter int RES_BITS   = RES_BITS_DEF,
  parameter int NUM_STAGES = NUM_STAGES_DEF
) (
  input  logic                clk,
  input  logic                rst_n,
  input  shbt_cmd_t           cmd,
  input  logic [2:0]          stage,
  input  logic [31:0]         read_mask,
  input  logic [31:0]         write_mask,
  input  logic                host_access,
  output logic [SYNC_W-1:0]   src_barrier,
  output logic [SYNC_W-1:0]   dst_barrier,
  output logic                barrier_taken
);
  localparam int MW = (RES_BITS < 32) ? RES_BITS : 32;

  logic [RES_BITS-1:0] rd_r  [NUM_STAGES][NUM_STAGES];
  logic [RES_BITS-1:0] wr_r  [NUM_STAGES][NUM_STAGES];
  logic [RES_BITS-1:0] rd_nxt[NUM_STAGES][NUM_STAGES];
  logic [RES_BITS-1:0] wr_nxt[NUM_STAGES][NUM_STAGES];
  logic [SYNC_W-1:0]   src_r, src_nxt, dst_r, dst_nxt, osrc_nxt, odst_nxt;
  logic [SYNC_W-1:0]   osrc_r, odst_r;
  logic                tk_r, tk_nxt;
  logic [RES_BITS-1:0] rm, wm;
  logic                st_ok;

  always_comb begin
    rm = '0;
    wm = '0;
    rm[MW-1:0] = read_mask[MW-1:0];
    wm[MW-1:0] = write_mask[MW-1:0];
    if (cmd.op == OP_JOIN) begin
      rm = '1;
      wm = '0;
    end
  end

  assign st_ok = stage < 3'(NUM_STAGES);

  always_comb begin
    rd_nxt = rd_r;
    wr_nxt = wr_r;
    src_nxt = src_r;
    dst_nxt = dst_r;
    tk_nxt = 1'b0;
    case (cmd.op)
      OP_USAGE, OP_JOIN: begin
        if (st_ok) begin
          for (int p = 0; p < NUM_STAGES; p++) begin
            if ((wr_r[stage][p] & wm) != '0) begin
              src_nxt |= sync_rd(3'(p)) | sync_wr(3'(p));
              dst_nxt |= sync_rd(stage) | sync_wr(stage);
              rd_nxt[stage][p] = '0;
              wr_nxt[stage][p] = '0;
            end else if ((wr_r[stage][p] & rm) != '0) begin
              src_nxt |= sync_rd(3'(p)) | sync_wr(3'(p));
              dst_nxt |= sync_rd(stage);
              rd_nxt[stage][p] = '0;
              wr_nxt[stage][p] = '0;
            end else if ((rd_r[stage][p] & wm) != '0) begin
              src_nxt |= sync_rd(3'(p));
              dst_nxt |= sync_wr(stage);
              rd_nxt[stage][p] = '0;
              wr_nxt[stage][p] = '0;
            end
          end
          if (cmd.op == OP_USAGE) begin
            if (host_access) dst_nxt |= SYNC_HOST;
            for (int p = 0; p < NUM_STAGES; p++) begin
              rd_nxt[p][stage] = rd_nxt[p][stage] | rm;
              wr_nxt[p][stage] = wr_nxt[p][stage] | wm;
            end
          end
        end
      end
      OP_CLRRD: begin
        for (int i = 0; i < NUM_STAGES; i++)
          for (int j = 0; j < NUM_STAGES; j++) rd_nxt[i][j] = '0;
      end
      OP_TAKE: begin
        if (dst_r != '0) begin
          tk_nxt = 1'b1;
          src_nxt = '0;
          dst_nxt = '0;
        end
      end
      OP_FRAME: begin
        for (int i = 0; i < NUM_STAGES; i++)
          for (int j = 0; j < NUM_STAGES; j++) begin
            rd_nxt[i][j] = '1;
            wr_nxt[i][j] = '0;
          end
      end
      default: ;
    endcase
    osrc_nxt = (cmd.op == OP_TAKE) ? src_r : src_nxt;
    odst_nxt = (cmd.op == OP_TAKE) ? dst_r : dst_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < NUM_STAGES; i++)
        for (int j = 0; j < NUM_STAGES; j++) begin
          rd_r[i][j] <= '1;
          wr_r[i][j] <= '0;
        end
      src_r <= '0;
      dst_r <= '0;
    end else if (cmd.go) begin
      rd_r <= rd_nxt;
      wr_r <= wr_nxt;
      src_r <= src_nxt;
      dst_r <= dst_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.go) begin
      osrc_r <= osrc_nxt;
      odst_r <= odst_nxt;
      tk_r   <= tk_nxt;
    end
  end

  assign src_barrier   = osrc_r;
  assign dst_barrier   = odst_r;
  assign barrier_taken = tk_r;
endmodule

// ===== src/shbt_ctrl.sv =====
// Controller: input/output handshake and result-valid tracking.
`timescale 1ns / 1ps
module shbt_ctrl import shbt_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_tvalid,
  output logic       in_tready,
  input  logic [2:0] op,
  output logic       out_tvalid,
  input  logic       out_tready,
  output shbt_cmd_t  cmd
);
  typedef enum logic [1:0] {
    S_EMPTY = 2'b01,
    S_FULL  = 2'b10
  } state_t;

  state_t state_r, state_nxt;

  assign in_tready  = (state_r == S_EMPTY) || out_tready;
  assign out_tvalid = (state_r == S_FULL);
  assign cmd        = '{go: in_tvalid && in_tready, op: op};

  always_comb begin
    case (state_r)
      S_EMPTY: state_nxt = cmd.go ? S_FULL : S_EMPTY;
      S_FULL:  state_nxt = (out_tready && !cmd.go) ? S_EMPTY : S_FULL;
      default: state_nxt = S_EMPTY;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= S_EMPTY;
    else        state_r <= state_nxt;
  end
endmodule
